// ===== rtl/hie_pkg.sv =====
// Package for the Hilbert index encoder: sizes, item types and the per-step transforms.
package hie_pkg;

  localparam int MAX_DIMS = 8;
  localparam int MAX_BITS = 8;
  localparam int COORD_W  = 8;
  localparam int CFG_W    = 4;
  localparam int IDX_W    = 64;
  localparam int NUM_LVL  = MAX_BITS - 1;

  // register indexes on the config port
  localparam logic CFG_DIMS = 1'b0;
  localparam logic CFG_BITS = 1'b1;

  typedef logic [MAX_DIMS-1:0][COORD_W-1:0] ax_t;

  typedef struct packed {
    logic [CFG_W-1:0] dims;
    logic [CFG_W-1:0] bits;
    ax_t              ax;
  } item_t;

  // one bit level: each live axis inverts or swaps the bits of axis 0 below the level
  function automatic ax_t level_xform(ax_t ax_in, logic [2:0] lvl, logic [CFG_W-1:0] dims);
    ax_t              ax;
    logic [COORD_W-1:0] low;
    logic [COORD_W-1:0] t;
    ax  = ax_in;
    low = COORD_W'((COORD_W+1)'(1) << lvl) - COORD_W'(1);
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (CFG_W'(j) < dims) begin
        if (ax[j][lvl]) begin
          ax[0] = ax[0] ^ low;
        end else begin
          t     = (ax[0] ^ ax[j]) & low;
          ax[0] = ax[0] ^ t;
          ax[j] = ax[j] ^ t;
        end
      end
    end
    return ax;
  endfunction

  // Gray encode across the axes, then undo the excess with the last axis
  function automatic ax_t gray_xform(ax_t ax_in, logic [CFG_W-1:0] dims,
                                     logic [CFG_W-1:0] bits);
    ax_t                ax;
    logic [COORD_W-1:0] last;
    logic [COORD_W-1:0] t;
    ax = ax_in;
    for (int j = 1; j < MAX_DIMS; j++) begin
      if (CFG_W'(j) < dims) begin
        ax[j] = ax[j] ^ ax[j-1];
      end
    end
    last = ax[3'(dims - CFG_W'(1))];
    t    = '0;
    for (int p = 1; p < MAX_BITS; p++) begin
      if (CFG_W'(p) < bits && last[p]) begin
        t = t ^ (COORD_W'((COORD_W+1)'(1) << p) - COORD_W'(1));
      end
    end
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (CFG_W'(j) < dims) begin
        ax[j] = ax[j] ^ t;
      end
    end
    return ax;
  endfunction

  // interleave: level i, axis j lands on bit dims*i + dims-1-j
  function automatic logic [IDX_W-1:0] interleave(ax_t ax, logic [CFG_W-1:0] dims,
                                                  logic [CFG_W-1:0] bits);
    logic [IDX_W-1:0] idx;
    logic [6:0]       pos;
    idx = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        pos = 7'(dims) * 7'(i) + 7'(dims) - 7'(1) - 7'(j);
        if (CFG_W'(i) < bits && CFG_W'(j) < dims) begin
          idx[pos[5:0]] = ax[j][i];
        end
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/hilbert_index_encode.sv =====
// Top level of the Hilbert index encoder: config registers, input capture and the pipeline.
// A request taken at an edge passes the input register, seven bit-level stages, the Gray
// stage and the interleave/result register before out_valid strobes.
// Throughput: one request per cycle; busy stays low, the level pipeline sets this rate.
// Reset (synchronous, rst_n low): all stages empty, dims_r = 2, bits_r = 8.
// Results cannot be stalled: each one is shown for exactly one cycle with out_valid.
module hilbert_index_encode
  import hie_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] in_coord_0,
  input  logic [COORD_W-1:0] in_coord_1,
  input  logic [COORD_W-1:0] in_coord_2,
  input  logic [COORD_W-1:0] in_coord_3,
  input  logic [COORD_W-1:0] in_coord_4,
  input  logic [COORD_W-1:0] in_coord_5,
  input  logic [COORD_W-1:0] in_coord_6,
  input  logic [COORD_W-1:0] in_coord_7,
  // result channel
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_hilbert_index,
  // config write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  // raw register values; clamping happens when a request is captured
  logic [CFG_W-1:0] dims_r;
  logic [CFG_W-1:0] bits_r;

  logic             in_vld_r;
  item_t            in_r;
  item_t            in_nxt;
  logic [CFG_W-1:0] dims_c;
  logic [CFG_W-1:0] bits_c;
  logic [COORD_W-1:0] coord_mask;
  ax_t              coords;

  logic             lvl_vld;
  item_t            lvl_item;

  // pipeline has no back pressure, so a request is taken every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= CFG_W'(2);
      bits_r <= CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIMS: dims_r <= cfg_wdata;
        CFG_BITS: bits_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // zero acts as one, anything over the maximum acts as the maximum
  always_comb begin
    dims_c = dims_r;
    if (dims_r == '0) begin
      dims_c = CFG_W'(1);
    end else if (dims_r > CFG_W'(MAX_DIMS)) begin
      dims_c = CFG_W'(MAX_DIMS);
    end
    bits_c = bits_r;
    if (bits_r == '0) begin
      bits_c = CFG_W'(1);
    end else if (bits_r > CFG_W'(MAX_BITS)) begin
      bits_c = CFG_W'(MAX_BITS);
    end
  end

  assign coord_mask = COORD_W'(((COORD_W+1)'(1) << bits_c) - (COORD_W+1)'(1));

  assign coords[0] = in_coord_0;
  assign coords[1] = in_coord_1;
  assign coords[2] = in_coord_2;
  assign coords[3] = in_coord_3;
  assign coords[4] = in_coord_4;
  assign coords[5] = in_coord_5;
  assign coords[6] = in_coord_6;
  assign coords[7] = in_coord_7;

  // unused axes are zeroed so they never feed the later stages
  always_comb begin
    in_nxt.dims = dims_c;
    in_nxt.bits = bits_c;
    for (int j = 0; j < MAX_DIMS; j++) begin
      in_nxt.ax[j] = (CFG_W'(j) < dims_c) ? (coords[j] & coord_mask) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
  end

  // invert/exchange per level, high to low
  hie_levels u_levels (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_item  (in_r),
    .out_vld  (lvl_vld),
    .out_item (lvl_item)
  );

  // Gray encode, then interleave into the result register
  hie_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (lvl_vld),
    .in_item (lvl_item),
    .out_vld (out_valid),
    .out_idx (out_hilbert_index)
  );

endmodule

// ===== rtl/hie_levels.sv =====
// Pipeline of bit-level transform stages, one register stage per level from high to low.
module hie_levels
  import hie_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  logic  vld_r [NUM_LVL];
  item_t pl_r  [NUM_LVL];

  for (genvar k = 0; k < NUM_LVL; k++) begin : g_lvl
    localparam logic [2:0] LVL = 3'(MAX_BITS - 1 - k);
    logic  vld_src;
    item_t pl_src;
    item_t pl_nxt;

    if (k == 0) begin : g_first
      assign vld_src = in_vld;
      assign pl_src  = in_item;
    end else begin : g_rest
      assign vld_src = vld_r[k-1];
      assign pl_src  = pl_r[k-1];
    end

    // a level at or above the bit count is a pass-through
    always_comb begin
      pl_nxt = pl_src;
      if (CFG_W'(LVL) < pl_src.bits) begin
        pl_nxt.ax = level_xform(pl_src.ax, LVL, pl_src.dims);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      pl_r[k] <= pl_nxt;
    end
  end

  assign out_vld  = vld_r[NUM_LVL-1];
  assign out_item = pl_r[NUM_LVL-1];

endmodule

// ===== rtl/hie_finish.sv =====
// Gray encode stage followed by the bit interleave into the result register.
module hie_finish
  import hie_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  item_t            in_item,
  output logic             out_vld,
  output logic [IDX_W-1:0] out_idx
);

  logic             gray_vld_r;
  item_t            gray_r;
  item_t            gray_nxt;
  logic             idx_vld_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;

  always_comb begin
    gray_nxt    = in_item;
    gray_nxt.ax = gray_xform(in_item.ax, in_item.dims, in_item.bits);
  end

  assign idx_nxt = interleave(gray_r.ax, gray_r.dims, gray_r.bits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_vld_r <= 1'b0;
      idx_vld_r  <= 1'b0;
    end else begin
      gray_vld_r <= in_vld;
      idx_vld_r  <= gray_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    gray_r <= gray_nxt;
    idx_r  <= idx_nxt;
  end

  assign out_vld = idx_vld_r;
  assign out_idx = idx_r;

endmodule

// ===== dv/hilbert_index_encode_tb.sv =====
// Self-checking testbench for the Hilbert index encoder: directed corners and random points.
module hilbert_index_encode_tb;
  import hie_pkg::*;

  // Distance from the accepting edge to the result strobe (the stages are listed in the block header).
  localparam int LATENCY        = 9;
  // Cycles with neither a request taken nor a result shown before the run is called hung.
  // Longest legal quiet stretch is a drain or a random sender gap at 79%.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 100;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [COORD_W-1:0] in_coord_0;
  logic [COORD_W-1:0] in_coord_1;
  logic [COORD_W-1:0] in_coord_2;
  logic [COORD_W-1:0] in_coord_3;
  logic [COORD_W-1:0] in_coord_4;
  logic [COORD_W-1:0] in_coord_5;
  logic [COORD_W-1:0] in_coord_6;
  logic [COORD_W-1:0] in_coord_7;
  logic               out_valid;
  logic [IDX_W-1:0]   out_hilbert_index;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  // Shadow copy of the two config registers, updated at the edge that writes them.
  logic [CFG_W-1:0]   dims_reg;
  logic [CFG_W-1:0]   bits_reg;

  // Expected Hilbert distances, oldest first.
  logic [IDX_W-1:0]   pending_index[$];
  int                 mismatches   = 0;
  int                 stall_cycles = 0;

  hilbert_index_encode uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_coord_0        (in_coord_0),
    .in_coord_1        (in_coord_1),
    .in_coord_2        (in_coord_2),
    .in_coord_3        (in_coord_3),
    .in_coord_4        (in_coord_4),
    .in_coord_5        (in_coord_5),
    .in_coord_6        (in_coord_6),
    .in_coord_7        (in_coord_7),
    .out_valid         (out_valid),
    .out_hilbert_index (out_hilbert_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor: distance of a point along the Hilbert curve for the given raw register
  // values. Out-of-range register values are clamped into 1..8 first.
  // ---------------------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] hilbert_distance(input ax_t pt,
                                                        input logic [CFG_W-1:0] dims_raw,
                                                        input logic [CFG_W-1:0] bits_raw);
    int                 n;
    int                 b;
    logic [COORD_W-1:0] keep;
    logic [COORD_W-1:0] below;
    logic [COORD_W-1:0] swap;
    logic [COORD_W-1:0] fix;
    ax_t                ax;
    logic [IDX_W-1:0]   hidx;
    n = (dims_raw == 0) ? 1 : (dims_raw > MAX_DIMS) ? MAX_DIMS : int'(dims_raw);
    b = (bits_raw == 0) ? 1 : (bits_raw > MAX_BITS) ? MAX_BITS : int'(bits_raw);
    keep = {COORD_W{1'b1}} >> (COORD_W - b);
    ax   = '0;
    for (int j = 0; j < n; j++) ax[j] = pt[j] & keep;

    // walk the levels from the top one down to bit 1: invert or swap axis 0's lower bits
    for (int lv = b - 1; lv >= 1; lv--) begin
      below = (COORD_W'(1) << lv) - COORD_W'(1);
      for (int j = 0; j < n; j++) begin
        if (ax[j][lv]) begin
          ax[0] = ax[0] ^ below;
        end else begin
          swap  = (ax[0] ^ ax[j]) & below;
          ax[0] = ax[0] ^ swap;
          ax[j] = ax[j] ^ swap;
        end
      end
    end

    // Gray code across axes, then correct with the last axis
    for (int j = 1; j < n; j++) ax[j] = ax[j] ^ ax[j-1];
    fix = '0;
    for (int lv = b - 1; lv >= 1; lv--) begin
      if (ax[n-1][lv]) fix = fix ^ ((COORD_W'(1) << lv) - COORD_W'(1));
    end
    for (int j = 0; j < n; j++) ax[j] = ax[j] ^ fix;

    // interleave, axis 0 on the top bit of each level
    hidx = '0;
    for (int i = 0; i < b; i++) begin
      for (int j = 0; j < n; j++) hidx[n*i + n - 1 - j] = ax[j][i];
    end
    return hidx;
  endfunction

  // Coordinate draw: mostly uniform, sometimes an edge value (zero, all ones or a single set bit).
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = COORD_W'(1) << $urandom_range(COORD_W - 1);
      default: v = COORD_W'($urandom_range(255));
    endcase
    return v;
  endfunction

  function automatic ax_t rand_point();
    ax_t pt;
    for (int j = 0; j < MAX_DIMS; j++) pt[j] = rand_coord();
    return pt;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver side. Every task is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------------------

  // Send one request and hold it until taken. start stays high on return unless a gap follows,
  // so back-to-back requests never see start lowered and raised in the same step; idle_pct decides
  // whether a gap follows.
  task automatic send_point(input ax_t pt, input int idle_pct);
    start      <= 1'b1;
    in_coord_0 <= pt[0];
    in_coord_1 <= pt[1];
    in_coord_2 <= pt[2];
    in_coord_3 <= pt[3];
    in_coord_4 <= pt[4];
    in_coord_5 <= pt[5];
    in_coord_6 <= pt[6];
    in_coord_7 <= pt[7];
    do @(posedge clk); while (busy !== 1'b0);
    // taken at this edge: registers cannot change while requests are in flight
    pending_index = {pending_index, hilbert_distance(pt, dims_reg, bits_reg)};
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    start <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_DIMS) dims_reg = val;
    else                 bits_reg = val;
  endtask

  // Both registers, only with the pipeline empty.
  task automatic set_shape(input logic [CFG_W-1:0] dims, input logic [CFG_W-1:0] bits);
    drain();
    write_cfg(CFG_DIMS, dims);
    write_cfg(CFG_BITS, bits);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset shape (2 dims, 8 bits): corners, plus junk on unused axes that must be ignored.
  task automatic test_reset_shape();
    send_point('0, 0);
    send_point({8{8'hFF}}, 0);
    send_point({8'hA5, 8'h3C, 8'hFF, 8'h81, 8'h77, 8'h12, 8'h00, 8'hFF}, 0);
    send_point({48'h0, 8'h80, 8'h01}, 0);
  endtask

  // Shape corners, including clamped register values and bits above the depth.
  task automatic test_shape_corners();
    // one level only: Gray code with no level transform
    set_shape(4'd1, 4'd1);
    send_point('0, 0);
    send_point({8{8'hFF}}, 0);
    set_shape(4'd8, 4'd1);
    send_point({8{8'h01}}, 0);
    send_point({8{8'hFE}}, 0);
    // widest index, all 64 bits live
    set_shape(4'd8, 4'd8);
    send_point({8{8'hFF}}, 0);
    send_point({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 0);
    send_point({56'h0, 8'h80}, 0);
    // single axis, full depth
    set_shape(4'd1, 4'd8);
    send_point({56'h0, 8'hFF}, 0);
    send_point({56'h0, 8'h6D}, 0);
    // zero registers act as one
    set_shape(4'd0, 4'd0);
    send_point({8{8'hFF}}, 0);
    send_point({8{8'h02}}, 0);
    // oversized registers act as eight
    set_shape(4'd15, 4'd15);
    send_point({8{8'hFF}}, 0);
    send_point({8'h01, 8'h80, 8'h7F, 8'hC3, 8'h00, 8'hFF, 8'h5A, 8'h99}, 0);
    set_shape(4'd9, 4'd0);
    send_point({8{8'hE7}}, 0);
    // depth 12 acts as eight; then depth 3, where bits 3..7 of every coordinate must be ignored
    set_shape(4'd3, 4'd12);
    send_point({8{8'hF8}}, 0);
    set_shape(4'd3, 4'd3);
    send_point({8{8'hFD}}, 0);
  endtask

  // Random points across several shapes and sender duty cycles.
  task automatic test_random_points();
    logic [CFG_W-1:0] dims;
    logic [CFG_W-1:0] bits;
    int               idle_pct;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin dims = 4'd8; bits = 4'd8; end
        1:       begin dims = 4'd1; bits = 4'd1; end
        2:       begin dims = 4'd1; bits = 4'd8; end
        3:       begin dims = 4'd8; bits = 4'd1; end
        default: begin
          dims = CFG_W'($urandom_range(15));
          bits = CFG_W'($urandom_range(15));
        end
      endcase
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        default: idle_pct = 8;
      endcase
      set_shape(dims, bits);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // in phase 4 the sender holds off mid-phase until the pipeline is empty
        if (p == 4 && k == PHASE_ITEMS / 2) drain();
        send_point(rand_point(), idle_pct);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result check: sampled at the edge that ends the strobe cycle.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_index.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hilbert_index=%h", out_hilbert_index);
      end else if (out_hilbert_index !== pending_index[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("hilbert_index mismatch: expected %h, got %h",
                   pending_index[0], out_hilbert_index);
        void'(pending_index.pop_front());
      end else begin
        void'(pending_index.pop_front());
      end
    end
  end

  // Watchdog: quiet cycles since the last request taken or result shown.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("hilbert_index_encode_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_coord_0   <= '0;
    in_coord_1   <= '0;
    in_coord_2   <= '0;
    in_coord_3   <= '0;
    in_coord_4   <= '0;
    in_coord_5   <= '0;
    in_coord_6   <= '0;
    in_coord_7   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_DIMS;
    cfg_wdata    <= '0;
    dims_reg     = 4'd2;
    bits_reg     = 4'd8;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_shape();
    test_shape_corners();
    test_random_points();

    // all results in, then a pipeline's worth of quiet to catch stray strobes
    drain();
    repeat (LATENCY + 2) @(posedge clk);
    if (mismatches == 0 && pending_index.size() == 0) begin
      $display("hilbert_index_encode_tb OK");
    end else begin
      $display("hilbert_index_encode_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hie_pkg.sv
rtl/hie_levels.sv
rtl/hie_finish.sv
rtl/hilbert_index_encode.sv
dv/hilbert_index_encode_tb.sv
